>>> rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, constants and the beep pattern table of the buzzer pattern
// sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int MAX_STEPS_DEF     = 10;
  localparam int PATTERN_COUNT_DEF = 14;

  localparam int ELAPSED_W = 10;
  localparam int STEP_W    = 11;
  localparam int PAT_W     = 4;
  localparam int IDX_W     = 4;

  typedef logic signed [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_START      = 2'd1,
    MODE_START_IDLE = 2'd2,
    MODE_STOP       = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [PAT_W-1:0]  pattern_id;
  } in_beat_t;

  typedef struct packed {
    logic              tone_on;
    logic              playing;
    logic [PAT_W-1:0]  active_pattern;
    logic              finished;
  } out_beat_t;

  typedef struct packed {
    logic                 busy;
    logic [PAT_W-1:0]     cur_pattern;
    logic [IDX_W-1:0]     step_index;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 tone;
    step_t                cur_step;
  } play_state_t;

  // signed millisecond steps, positive tone on, negative silence, zero ends
  function automatic step_t beep_value(input logic [PAT_W-1:0] pat,
                                       input logic [IDX_W-1:0] idx);
    step_t row [8];
    row = '{default: '0};
    unique case (pat)
      4'd1: row = '{11'sd150, -11'sd100, 11'sd150, '0, '0, '0, '0, '0};
      4'd2: row = '{11'sd100, -11'sd80, 11'sd100, -11'sd80, 11'sd100, '0, '0, '0};
      4'd3: row = '{11'sd800, '0, '0, '0, '0, '0, '0, '0};
      4'd4: row = '{11'sd100, -11'sd100, 11'sd100, -11'sd100, 11'sd100, '0, '0, '0};
      4'd5: row = '{11'sd400, -11'sd400, 11'sd400, '0, '0, '0, '0, '0};
      4'd6: row = '{11'sd400, -11'sd400, 11'sd400, -11'sd400, 11'sd400, '0, '0, '0};
      4'd7: row = '{11'sd400, -11'sd400, 11'sd400, -11'sd400, 11'sd400, -11'sd300,
                    11'sd200, '0};
      4'd8: row = '{11'sd100, '0, '0, '0, '0, '0, '0, '0};
      4'd9: row = '{11'sd400, -11'sd400, 11'sd400, '0, '0, '0, '0, '0};
      4'd10: row = '{11'sd200, '0, '0, '0, '0, '0, '0, '0};
      4'd11: row = '{11'sd800, '0, '0, '0, '0, '0, '0, '0};
      4'd12: row = '{11'sd800, '0, '0, '0, '0, '0, '0, '0};
      4'd13: row = '{11'sd20, -11'sd30, '0, '0, '0, '0, '0, '0};
      default: row = '{default: '0};
    endcase
    return idx[IDX_W-1] ? step_t'(0) : row[idx[IDX_W-2:0]];
  endfunction

endpackage

>>> rtl/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Plays fixed on/off beep patterns from a built-in table, driven by tick,
// start, start-if-idle and stop beats.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled and returns one
// result beat per input beat, registered first in the input stage and then in
// the output register. The pattern table is a registered-read ROM: it is
// addressed from the committed playback state of the cycle, so the entry for
// the following step and the first entry of the requested pattern are ready
// when the next beat is evaluated. Starting pattern zero or one outside the
// table stops playback without the finished flag.
module buzzer_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int MAX_STEPS     = MAX_STEPS_DEF,
  parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam logic [ELAPSED_W-1:0] ElapsedMax = '1;

  logic        s1_valid_q, s1_valid_d;
  in_beat_t    s1_q;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, res;
  play_state_t st_q, st_d, st_new;
  step_t       rom_start_q, rom_next_q;

  logic                 advance, commit, load, fin;
  logic [PAT_W-1:0]     id_nx;
  logic [STEP_W-1:0]    mag;
  logic [ELAPSED_W-1:0] el_inc;
  logic [IDX_W:0]       step_n;

  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  assign s1_valid_d  = load ? 1'b1 : (commit ? 1'b0 : s1_valid_q);
  assign out_valid_d = commit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  assign mag    = st_q.cur_step[STEP_W-1] ? $unsigned(-st_q.cur_step)
                                          : $unsigned(st_q.cur_step);
  assign el_inc = (st_q.elapsed_ms == ElapsedMax) ? st_q.elapsed_ms
                                                  : st_q.elapsed_ms + 1'b1;
  assign step_n = {1'b0, st_q.step_index} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    st_new = st_q;
    fin    = 1'b0;
    case (s1_q.mode) inside
      MODE_TICK: begin
        if (st_q.busy) begin
          if ({{(STEP_W-ELAPSED_W){1'b0}}, el_inc} >= mag) begin
            st_new.elapsed_ms = '0;
            st_new.step_index = step_n[IDX_W-1:0];
            if (step_n >= (IDX_W+1)'(MAX_STEPS) || rom_next_q == '0) begin
              st_new.tone        = 1'b0;
              st_new.busy        = 1'b0;
              st_new.cur_pattern = '0;
              fin                = 1'b1;
            end else begin
              st_new.tone     = !rom_next_q[STEP_W-1];
              st_new.cur_step = rom_next_q;
            end
          end else begin
            st_new.elapsed_ms = el_inc;
          end
        end
      end
      MODE_START, MODE_START_IDLE: begin
        if (s1_q.mode == MODE_START || !st_q.busy) begin
          if (s1_q.pattern_id == '0 ||
              {1'b0, s1_q.pattern_id} >= (PAT_W+1)'(PATTERN_COUNT)) begin
            st_new.tone        = 1'b0;
            st_new.busy        = 1'b0;
            st_new.cur_pattern = '0;
          end else begin
            st_new.cur_pattern = s1_q.pattern_id;
            st_new.step_index  = '0;
            st_new.elapsed_ms  = '0;
            if (rom_start_q == '0) begin
              st_new.tone        = 1'b0;
              st_new.busy        = 1'b0;
              st_new.cur_pattern = '0;
              fin                = 1'b1;
            end else begin
              st_new.busy     = 1'b1;
              st_new.tone     = !rom_start_q[STEP_W-1];
              st_new.cur_step = rom_start_q;
            end
          end
        end
      end
      default: begin
        st_new.tone        = 1'b0;
        st_new.busy        = 1'b0;
        st_new.cur_pattern = '0;
      end
    endcase
  end

  assign st_d = commit ? st_new : st_q;

  always_comb begin
    res.tone_on        = st_new.tone;
    res.playing        = st_new.busy;
    res.active_pattern = st_new.cur_pattern;
    res.finished       = fin;
  end

  assign id_nx = load ? in_beat_i.pattern_id : s1_q.pattern_id;

  // pattern rom, registered read at the state seen by the next beat
  always_ff @(posedge clk_i) begin
    rom_start_q <= beep_value(id_nx, '0);
    rom_next_q  <= beep_value(st_d.cur_pattern, st_d.step_index + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q <= in_beat_i;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
